// File: rtl/core/udpfhr_pkg.sv
package udpfhr_pkg;

   localparam int MAX_FRAME = 2048;
   localparam int OFFSET_W = 12;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 48;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_NEW_SOURCE_IP  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEW_DEST_IP    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEW_SOURCE_MAC = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEW_DEST_MAC   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_PORT     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEW_DEST_PORT  = 3'd5;

   localparam logic [31:0] RST_NEW_SOURCE_IP  = 32'd3232235877;
   localparam logic [31:0] RST_NEW_DEST_IP    = 32'd3232235876;
   localparam logic [47:0] RST_NEW_SOURCE_MAC = 48'd193675817098143;
   localparam logic [47:0] RST_NEW_DEST_MAC   = 48'd0;
   localparam logic [15:0] RST_MATCH_PORT     = 16'd9999;
   localparam logic [15:0] RST_NEW_DEST_PORT  = 16'd9000;

   localparam logic [OFFSET_W-1:0] OFF_IP_HDR   = 12'd14;
   localparam logic [OFFSET_W-1:0] OFF_PROTO    = 12'd23;
   localparam logic [OFFSET_W-1:0] OFF_IP_CHECK = 12'd24;
   localparam logic [OFFSET_W-1:0] OFF_SRC_IP   = 12'd26;
   localparam logic [OFFSET_W-1:0] OFF_DST_IP   = 12'd30;
   localparam logic [OFFSET_W-1:0] OFF_UDP_HDR  = 12'd34;
   localparam logic [OFFSET_W-1:0] OFF_DST_PORT = 12'd36;
   localparam logic [OFFSET_W-1:0] OFF_UDP_CHECK = 12'd40;
   localparam logic [OFFSET_W-1:0] MIN_FORWARD_LEN = 12'd42;

   localparam logic [7:0]  PROTO_UDP = 8'h11;

   typedef struct packed {
      logic                forward;
      logic [15:0]         ip_sum;
      logic [15:0]         udp_sum;
      logic [7:0]          high_byte;
      logic [OFFSET_W-1:0] frame_length;
   } frame_summary_type;

   function automatic logic [15:0] fold16(input logic [19:0] value);
      logic [16:0] partial;
      partial = {1'b0, value[15:0]} + 17'(value[19:16]);
      return partial[15:0] + 16'(partial[16]);
   endfunction

endpackage

// File: rtl/core/udpfhr_front.sv
module udpfhr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [7:0]                    frame_byte,
   input  logic                          last_byte,
   input  logic [31:0]                   new_source_ip,
   input  logic [31:0]                   new_dest_ip,
   input  logic [15:0]                   match_port,
   input  logic [15:0]                   new_dest_port,
   output logic                          push,
   output udpfhr_pkg::frame_summary_type summary
);

   logic [udpfhr_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic [3:0]  header_words_ff, header_words_in;
   logic [15:0] ip_sum_ff, ip_sum_in;
   logic [15:0] udp_sum_ff, udp_sum_in;
   logic [7:0]  hold_ff, hold_in;
   logic        protocol_ok_ff, protocol_ok_in;
   logic [7:0]  port_high_ff, port_high_in;
   logic        port_ok_ff, port_ok_in;

   logic [udpfhr_pkg::OFFSET_W-1:0] o, ip_end, len;
   logic        in_range;
   logic [7:0]  v, u;
   logic [15:0] ip_word;

   always_comb begin
      o = offset_ff;
      in_range = offset_ff < udpfhr_pkg::OFFSET_W'(udpfhr_pkg::MAX_FRAME);
      offset_in = offset_ff;
      header_words_in = header_words_ff;
      ip_sum_in = ip_sum_ff;
      udp_sum_in = udp_sum_ff;
      hold_in = hold_ff;
      protocol_ok_in = protocol_ok_ff;
      port_high_in = port_high_ff;
      port_ok_in = port_ok_ff;

      if (o == udpfhr_pkg::OFF_IP_HDR) begin
         header_words_in = frame_byte[3:0];
      end
      if (o == udpfhr_pkg::OFF_PROTO) begin
         protocol_ok_in = (frame_byte == udpfhr_pkg::PROTO_UDP);
      end
      if (o == udpfhr_pkg::OFF_DST_PORT) begin
         port_high_in = frame_byte;
      end
      if (o == udpfhr_pkg::OFF_DST_PORT + 12'd1) begin
         port_ok_in = ({port_high_ff, frame_byte} == match_port);
      end

      case (o)
         udpfhr_pkg::OFF_IP_CHECK,
         udpfhr_pkg::OFF_IP_CHECK + 12'd1:  v = 8'h00;
         udpfhr_pkg::OFF_SRC_IP:            v = new_source_ip[31:24];
         udpfhr_pkg::OFF_SRC_IP + 12'd1:    v = new_source_ip[23:16];
         udpfhr_pkg::OFF_SRC_IP + 12'd2:    v = new_source_ip[15:8];
         udpfhr_pkg::OFF_SRC_IP + 12'd3:    v = new_source_ip[7:0];
         udpfhr_pkg::OFF_DST_IP:            v = new_dest_ip[31:24];
         udpfhr_pkg::OFF_DST_IP + 12'd1:    v = new_dest_ip[23:16];
         udpfhr_pkg::OFF_DST_IP + 12'd2:    v = new_dest_ip[15:8];
         udpfhr_pkg::OFF_DST_IP + 12'd3:    v = new_dest_ip[7:0];
         udpfhr_pkg::OFF_DST_PORT:          v = new_dest_port[15:8];
         udpfhr_pkg::OFF_DST_PORT + 12'd1:  v = new_dest_port[7:0];
         default:                           v = frame_byte;
      endcase

      case (o)
         udpfhr_pkg::OFF_DST_PORT:          u = new_dest_port[15:8];
         udpfhr_pkg::OFF_DST_PORT + 12'd1:  u = new_dest_port[7:0];
         udpfhr_pkg::OFF_UDP_CHECK,
         udpfhr_pkg::OFF_UDP_CHECK + 12'd1: u = 8'h00;
         default:                           u = frame_byte;
      endcase

      ip_end = udpfhr_pkg::OFF_IP_HDR + {6'd0, header_words_in, 2'b00};
      ip_word = o[0] ? {8'h00, v} : {v, 8'h00};
      if (o >= udpfhr_pkg::OFF_IP_HDR && o < ip_end) begin
         ip_sum_in = udpfhr_pkg::fold16({4'd0, ip_sum_ff} + {4'd0, ip_word});
      end

      if (o >= udpfhr_pkg::OFF_UDP_HDR) begin
         if (!o[0]) begin
            hold_in = u;
         end else begin
            udp_sum_in = udpfhr_pkg::fold16({4'd0, udp_sum_ff} + {4'd0, hold_ff, u});
         end
      end

      offset_in = o + 12'd1;

      if (!in_range) begin
         offset_in = offset_ff;
         header_words_in = header_words_ff;
         ip_sum_in = ip_sum_ff;
         udp_sum_in = udp_sum_ff;
         hold_in = hold_ff;
         protocol_ok_in = protocol_ok_ff;
         port_high_in = port_high_ff;
         port_ok_in = port_ok_ff;
      end

      len = offset_in;
      push = accept && last_byte;
      summary.forward = protocol_ok_in && port_ok_in && (len >= udpfhr_pkg::MIN_FORWARD_LEN);
      summary.ip_sum = ip_sum_in;
      summary.udp_sum = udp_sum_in;
      summary.high_byte = hold_in;
      summary.frame_length = len;
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         offset_ff <= '0;
         header_words_ff <= '0;
         ip_sum_ff <= '0;
         udp_sum_ff <= '0;
         hold_ff <= '0;
         protocol_ok_ff <= 1'b0;
         port_high_ff <= '0;
         port_ok_ff <= 1'b0;
      end else if (accept) begin
         offset_ff <= offset_in;
         header_words_ff <= header_words_in;
         ip_sum_ff <= ip_sum_in;
         udp_sum_ff <= udp_sum_in;
         hold_ff <= hold_in;
         protocol_ok_ff <= protocol_ok_in;
         port_high_ff <= port_high_in;
         port_ok_ff <= port_ok_in;
      end
   end

endmodule

// File: rtl/core/udpfhr_queue.sv
module udpfhr_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  udpfhr_pkg::frame_summary_type push_data,
   output logic                          full,
   input  logic                          pop,
   output logic                          not_empty,
   output udpfhr_pkg::frame_summary_type pop_data
);

   udpfhr_pkg::frame_summary_type entries_ff [udpfhr_pkg::QUEUE_DEPTH];
   logic [udpfhr_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [udpfhr_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [udpfhr_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      full = (count_ff == udpfhr_pkg::QUEUE_CNT_W'(udpfhr_pkg::QUEUE_DEPTH));
      not_empty = (count_ff != '0);
      pop_data = entries_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == udpfhr_pkg::QUEUE_PTR_W'(udpfhr_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == udpfhr_pkg::QUEUE_PTR_W'(udpfhr_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/udpfhr_back.sv
module udpfhr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [31:0]                   new_source_ip,
   input  logic [31:0]                   new_dest_ip,
   input  logic                          entry_valid,
   input  udpfhr_pkg::frame_summary_type entry,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [63:0]                   rsp_tdata,
   output logic                          rsp_tuser
);

   logic [15:0] pseudo_sum_ff, pseudo_sum_in;
   logic        valid_ff;
   logic        forward_ff;
   logic [15:0] ip_check_ff, udp_check_ff, udp_len_ff;
   logic [udpfhr_pkg::OFFSET_W-1:0] frame_length_ff;

   logic [18:0] pseudo_raw;
   logic [15:0] ulen, odd_word, udp_total;
   logic [17:0] udp_raw;

   always_comb begin
      pseudo_raw = 19'(new_source_ip[31:16]) + 19'(new_source_ip[15:0])
                 + 19'(new_dest_ip[31:16]) + 19'(new_dest_ip[15:0])
                 + 19'(udpfhr_pkg::PROTO_UDP);
      pseudo_sum_in = udpfhr_pkg::fold16({1'b0, pseudo_raw});

      ulen = {4'd0, entry.frame_length} - {4'd0, udpfhr_pkg::OFF_UDP_HDR};
      odd_word = (entry.frame_length > udpfhr_pkg::OFF_UDP_HDR && entry.frame_length[0])
                 ? {entry.high_byte, 8'h00} : 16'h0000;
      udp_raw = 18'(entry.udp_sum) + 18'(odd_word) + 18'(ulen) + 18'(pseudo_sum_ff);
      udp_total = udpfhr_pkg::fold16({2'b00, udp_raw});

      pop = entry_valid && (!valid_ff || rsp_tready);
      rsp_tvalid = valid_ff;
      rsp_tuser = forward_ff;
      rsp_tdata = {4'd0, frame_length_ff, udp_len_ff, udp_check_ff, ip_check_ff};
   end

   always_ff @(posedge clock) begin
      pseudo_sum_ff <= pseudo_sum_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
      if (pop) begin
         forward_ff <= entry.forward;
         ip_check_ff <= ~entry.ip_sum;
         udp_check_ff <= ~udp_total;
         udp_len_ff <= ulen;
         frame_length_ff <= entry.frame_length;
      end
   end

endmodule

// File: rtl/core/udp_forward_header_rewrite_core.sv
// Channel   Direction  Handshake                Payload
// req       in         req_tvalid/req_tready    tdata frame_byte, tlast last_byte
// rsp       out        rsp_tvalid/rsp_tready    tdata checksums and lengths, tuser forward
// csr       in         csr_wr_en                csr_index, csr_wr_data
//
// One word is accepted per cycle while the queue is not full; each byte only updates
// running sums in the front part. Each result passes a two-entry queue and an output
// register, so frames of any length, even one word, keep full rate if results are taken.
// Reset is synchronous and restores the register defaults and an empty frame.
// The input stalls only when the queue is full because results are not being taken.
module udp_forward_header_rewrite_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // [7:0] frame_byte
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] ip_checksum, [31:16] udp_checksum, [47:32] udp_len, [59:48] frame_length
   output logic [63:0]                          rsp_tdata,
   output logic                                 rsp_tuser,   // [0] forward
   input  logic                                 csr_wr_en,
   input  logic [udpfhr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [udpfhr_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   logic [31:0] new_source_ip_ff;
   logic [31:0] new_dest_ip_ff;
   logic [47:0] new_source_mac_ff;
   logic [47:0] new_dest_mac_ff;
   logic [15:0] match_port_ff;
   logic [15:0] new_dest_port_ff;

   logic accept, push, full, pop, not_empty;
   udpfhr_pkg::frame_summary_type push_data, pop_data;

   assign req_tready = !full;
   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         new_source_ip_ff <= udpfhr_pkg::RST_NEW_SOURCE_IP;
         new_dest_ip_ff <= udpfhr_pkg::RST_NEW_DEST_IP;
         new_source_mac_ff <= udpfhr_pkg::RST_NEW_SOURCE_MAC;
         new_dest_mac_ff <= udpfhr_pkg::RST_NEW_DEST_MAC;
         match_port_ff <= udpfhr_pkg::RST_MATCH_PORT;
         new_dest_port_ff <= udpfhr_pkg::RST_NEW_DEST_PORT;
      end else if (csr_wr_en) begin
         case (csr_index)
            udpfhr_pkg::CSR_NEW_SOURCE_IP:  new_source_ip_ff <= csr_wr_data[31:0];
            udpfhr_pkg::CSR_NEW_DEST_IP:    new_dest_ip_ff <= csr_wr_data[31:0];
            udpfhr_pkg::CSR_NEW_SOURCE_MAC: new_source_mac_ff <= csr_wr_data;
            udpfhr_pkg::CSR_NEW_DEST_MAC:   new_dest_mac_ff <= csr_wr_data;
            udpfhr_pkg::CSR_MATCH_PORT:     match_port_ff <= csr_wr_data[15:0];
            udpfhr_pkg::CSR_NEW_DEST_PORT:  new_dest_port_ff <= csr_wr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   udpfhr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .frame_byte    (req_tdata),
      .last_byte     (req_tlast),
      .new_source_ip (new_source_ip_ff),
      .new_dest_ip   (new_dest_ip_ff),
      .match_port    (match_port_ff),
      .new_dest_port (new_dest_port_ff),
      .push          (push),
      .summary       (push_data)
   );

   udpfhr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   udpfhr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .new_source_ip (new_source_ip_ff),
      .new_dest_ip   (new_dest_ip_ff),
      .entry_valid   (not_empty),
      .entry         (pop_data),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser)
   );

endmodule

// File: dv/udp_forward_header_rewrite_core_test.sv
`timescale 1ns / 100ps

module udp_forward_header_rewrite_core_test;

   typedef struct packed {
      logic        forward;
      logic [15:0] ip_checksum;
      logic [15:0] udp_checksum;
      logic [15:0] udp_len;
      logic [11:0] frame_length;
   } result_word_type;

   typedef struct packed {
      logic [15:0] len;
      logic [3:0]  ihl;
      logic [7:0]  proto;
      logic [15:0] port;
      logic [7:0]  fill;
      logic        rand_fill;
      logic        typed;
      logic        t_forward;
      logic        t_ip_known;
      logic [15:0] t_ip_ck;
      logic [15:0] t_udp_len;
      logic [11:0] t_flen;
   } stim_row_type;

   localparam int CASE_COUNT = 14;
   localparam logic [7:0]  UDP = udpfhr_pkg::PROTO_UDP;
   localparam logic [15:0] MATCH = udpfhr_pkg::RST_MATCH_PORT;
   localparam logic [15:0] OTHER_PORT = udpfhr_pkg::RST_MATCH_PORT - 16'd1;

   // Rows with typed set carry the forward flag, lengths and, where known, the IP checksum.
   localparam stim_row_type frame_cases [CASE_COUNT] = '{
      '{16'd1,    4'd5,  UDP,   MATCH,      8'h00, 1'b0, 1'b1, 1'b0, 1'b1,
        16'hFFFF, 16'hFFDF, 12'd1},
      '{16'd34,   4'd0,  8'h00, 16'h0000,   8'h00, 1'b0, 1'b1, 1'b0, 1'b1,
        16'hFFFF, 16'h0000, 12'd34},
      '{16'd33,   4'd5,  UDP,   MATCH,      8'h00, 1'b1, 1'b1, 1'b0, 1'b0,
        16'h0000, 16'hFFFF, 12'd33},
      '{16'd35,   4'd5,  UDP,   MATCH,      8'h00, 1'b1, 1'b1, 1'b0, 1'b0,
        16'h0000, 16'd1,    12'd35},
      '{16'd41,   4'd5,  UDP,   MATCH,      8'h00, 1'b1, 1'b1, 1'b0, 1'b0,
        16'h0000, 16'd7,    12'd41},
      '{16'd42,   4'd5,  UDP,   MATCH,      8'h00, 1'b1, 1'b1, 1'b1, 1'b0,
        16'h0000, 16'd8,    12'd42},
      '{16'd43,   4'd5,  UDP,   MATCH,      8'h00, 1'b1, 1'b1, 1'b1, 1'b0,
        16'h0000, 16'd9,    12'd43},
      '{16'd60,   4'd15, UDP,   MATCH,      8'hFF, 1'b0, 1'b0, 1'b0, 1'b0,
        16'h0000, 16'h0000, 12'd0},
      '{16'd100,  4'd5,  8'h06, MATCH,      8'h00, 1'b1, 1'b1, 1'b0, 1'b0,
        16'h0000, 16'd66,   12'd100},
      '{16'd100,  4'd5,  UDP,   OTHER_PORT, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0,
        16'h0000, 16'd66,   12'd100},
      '{16'd64,   4'd0,  8'hFF, 16'hFFFF,   8'hFF, 1'b0, 1'b1, 1'b0, 1'b1,
        16'hFFFF, 16'd30,   12'd64},
      '{16'd2050, 4'd5,  UDP,   MATCH,      8'h00, 1'b0, 1'b1, 1'b1, 1'b0,
        16'h0000, 16'd2014, 12'd2048},
      '{16'd80,   4'd5,  UDP,   MATCH,      8'h00, 1'b1, 1'b0, 1'b0, 1'b0,
        16'h0000, 16'h0000, 12'd0},
      '{16'd90,   4'd1,  UDP,   MATCH,      8'h00, 1'b1, 1'b0, 1'b0, 1'b0,
        16'h0000, 16'h0000, 12'd0}
   };

   logic                               clock       = 1'b0;
   logic                               reset       = 1'b1;
   logic                               req_tvalid  = 1'b0;
   logic [7:0]                         req_tdata   = 8'h00;
   logic                               req_tlast   = 1'b0;
   logic                               rsp_tready  = 1'b0;
   logic                               csr_wr_en   = 1'b0;
   logic [udpfhr_pkg::CSR_INDEX_W-1:0] csr_index   = udpfhr_pkg::CSR_NEW_SOURCE_IP;
   logic [udpfhr_pkg::CSR_DATA_W-1:0]  csr_wr_data = '0;
   logic                               req_tready;
   logic                               rsp_tvalid;
   logic [63:0]                        rsp_tdata;
   logic                               rsp_tuser;

   bit [31:0] cfg_src_ip   = udpfhr_pkg::RST_NEW_SOURCE_IP;
   bit [31:0] cfg_dst_ip   = udpfhr_pkg::RST_NEW_DEST_IP;
   bit [47:0] cfg_src_mac  = udpfhr_pkg::RST_NEW_SOURCE_MAC;
   bit [47:0] cfg_dst_mac  = udpfhr_pkg::RST_NEW_DEST_MAC;
   bit [15:0] cfg_match    = udpfhr_pkg::RST_MATCH_PORT;
   bit [15:0] cfg_dst_port = udpfhr_pkg::RST_NEW_DEST_PORT;

   int unsigned frame_offset = 0;
   bit [3:0]    ihl_seen     = '0;
   bit [15:0]   ip_acc       = '0;
   bit [15:0]   udp_acc      = '0;
   bit [7:0]    held_high    = '0;
   bit          proto_udp    = 1'b0;
   bit [7:0]    port_high    = '0;
   bit          port_match   = 1'b0;

   result_word_type pending_summaries[$];
   bit [7:0]        frame_bytes[$];
   bit              pin_typed = 1'b0;
   stim_row_type    pin_case;
   int              mismatches    = 0;
   int              send_idle_pct = 0;
   int              stall_pct     = 0;
   int              phase_bytes   = 0;
   int              phase_frames  = 0;

   udp_forward_header_rewrite_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   function automatic bit [15:0] ones_add(input bit [15:0] acc, input bit [15:0] value);
      bit [16:0] total;
      total = {1'b0, acc} + {1'b0, value};
      return total[15:0] + 16'(total[16]);
   endfunction

   function automatic bit rewrite_byte(input bit [7:0] b, input bit last,
                                       output result_word_type summary);
      int unsigned o;
      int unsigned len;
      bit [7:0]    ip_v;
      bit [7:0]    udp_v;
      bit [15:0]   ulen;
      bit [15:0]   total;
      summary = '0;
      if (frame_offset < udpfhr_pkg::MAX_FRAME) begin
         o = frame_offset;
         if (o == udpfhr_pkg::OFF_IP_HDR) ihl_seen = b[3:0];
         if (o == udpfhr_pkg::OFF_PROTO) proto_udp = (b == udpfhr_pkg::PROTO_UDP);
         if (o == udpfhr_pkg::OFF_DST_PORT) port_high = b;
         if (o == udpfhr_pkg::OFF_DST_PORT + 1) port_match = ({port_high, b} == cfg_match);
         ip_v = b;
         if (o == udpfhr_pkg::OFF_IP_CHECK || o == udpfhr_pkg::OFF_IP_CHECK + 1) begin
            ip_v = 8'h00;
         end else if (o >= udpfhr_pkg::OFF_SRC_IP && o <= udpfhr_pkg::OFF_SRC_IP + 3) begin
            ip_v = 8'(cfg_src_ip >> (8 * (udpfhr_pkg::OFF_SRC_IP + 3 - o)));
         end else if (o >= udpfhr_pkg::OFF_DST_IP && o <= udpfhr_pkg::OFF_DST_IP + 3) begin
            ip_v = 8'(cfg_dst_ip >> (8 * (udpfhr_pkg::OFF_DST_IP + 3 - o)));
         end else if (o == udpfhr_pkg::OFF_DST_PORT) begin
            ip_v = cfg_dst_port[15:8];
         end else if (o == udpfhr_pkg::OFF_DST_PORT + 1) begin
            ip_v = cfg_dst_port[7:0];
         end
         if (o >= udpfhr_pkg::OFF_IP_HDR &&
             o < udpfhr_pkg::OFF_IP_HDR + 4 * int'(ihl_seen)) begin
            ip_acc = ones_add(ip_acc, o[0] ? {8'h00, ip_v} : {ip_v, 8'h00});
         end
         if (o >= udpfhr_pkg::OFF_UDP_HDR) begin
            udp_v = b;
            if (o == udpfhr_pkg::OFF_DST_PORT) udp_v = cfg_dst_port[15:8];
            else if (o == udpfhr_pkg::OFF_DST_PORT + 1) udp_v = cfg_dst_port[7:0];
            else if (o == udpfhr_pkg::OFF_UDP_CHECK || o == udpfhr_pkg::OFF_UDP_CHECK + 1)
               udp_v = 8'h00;
            if (!o[0]) held_high = udp_v;
            else udp_acc = ones_add(udp_acc, {held_high, udp_v});
         end
         frame_offset++;
      end
      if (!last) return 1'b0;
      len   = frame_offset;
      ulen  = 16'(len - udpfhr_pkg::OFF_UDP_HDR);
      total = udp_acc;
      if (len > udpfhr_pkg::OFF_UDP_HDR && len[0]) total = ones_add(total, {held_high, 8'h00});
      total = ones_add(total, cfg_src_ip[31:16]);
      total = ones_add(total, cfg_src_ip[15:0]);
      total = ones_add(total, cfg_dst_ip[31:16]);
      total = ones_add(total, cfg_dst_ip[15:0]);
      total = ones_add(total, {8'h00, udpfhr_pkg::PROTO_UDP});
      total = ones_add(total, ulen);
      summary.forward      = proto_udp && port_match && (len >= udpfhr_pkg::MIN_FORWARD_LEN);
      summary.ip_checksum  = ~ip_acc;
      summary.udp_checksum = ~total;
      summary.udp_len      = ulen;
      summary.frame_length = 12'(len);
      frame_offset = 0;
      ihl_seen     = '0;
      ip_acc       = '0;
      udp_acc      = '0;
      held_high    = '0;
      proto_udp    = 1'b0;
      port_high    = '0;
      port_match   = 1'b0;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : rsp_check
      result_word_type want;
      result_word_type got;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got.forward      = rsp_tuser;
         got.ip_checksum  = rsp_tdata[15:0];
         got.udp_checksum = rsp_tdata[31:16];
         got.udp_len      = rsp_tdata[47:32];
         got.frame_length = rsp_tdata[59:48];
         if (pending_summaries.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: unexpected result word %h", $time, got);
            end
         end else begin
            want = pending_summaries.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: fwd %b/%b ip %h/%h udp %h/%h ulen %h/%h flen %0d/%0d (exp/act)",
                           $time, want.forward, got.forward, want.ip_checksum,
                           got.ip_checksum, want.udp_checksum, got.udp_checksum,
                           want.udp_len, got.udp_len, want.frame_length,
                           got.frame_length);
               end
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic push_byte(input bit [7:0] b, input bit last);
      result_word_type summary;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      if (rewrite_byte(b, last, summary)) begin
         if (pin_typed) begin
            summary.forward      = pin_case.t_forward;
            summary.udp_len      = pin_case.t_udp_len;
            summary.frame_length = pin_case.t_flen;
            if (pin_case.t_ip_known) summary.ip_checksum = pin_case.t_ip_ck;
         end
         pending_summaries.push_back(summary);
      end
   endtask

   task automatic build_frame(input int unsigned len, input bit [3:0] ihl, input bit [7:0] proto,
                              input bit [15:0] port, input bit [7:0] fill, input bit rand_fill);
      frame_bytes.delete();
      for (int unsigned i = 0; i < len; i++) begin
         frame_bytes.push_back(rand_fill ? 8'($urandom) : fill);
      end
      if (len > udpfhr_pkg::OFF_IP_HDR) begin
         frame_bytes[udpfhr_pkg::OFF_IP_HDR] = {frame_bytes[udpfhr_pkg::OFF_IP_HDR][7:4], ihl};
      end
      if (len > udpfhr_pkg::OFF_PROTO) frame_bytes[udpfhr_pkg::OFF_PROTO] = proto;
      if (len > udpfhr_pkg::OFF_DST_PORT) frame_bytes[udpfhr_pkg::OFF_DST_PORT] = port[15:8];
      if (len > udpfhr_pkg::OFF_DST_PORT + 1) begin
         frame_bytes[udpfhr_pkg::OFF_DST_PORT + 1] = port[7:0];
      end
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_bytes.size(); i++) begin
         push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      end
      phase_bytes  += frame_bytes.size();
      phase_frames += 1;
   endtask

   task automatic send_random_frame();
      int unsigned pick;
      int unsigned len;
      bit [3:0]    ihl;
      bit [7:0]    proto;
      bit [15:0]   port;
      pick = $urandom_range(99);
      if (pick < 10) len = $urandom_range(41, 1);
      else if (pick < 85) len = $urandom_range(90, 42);
      else len = $urandom_range(300, 91);
      ihl   = ($urandom_range(99) < 85) ? 4'd5 : 4'($urandom_range(15));
      proto = ($urandom_range(99) < 85) ? udpfhr_pkg::PROTO_UDP : 8'($urandom);
      port  = ($urandom_range(99) < 75) ? cfg_match : 16'($urandom);
      build_frame(len, ihl, proto, port, 8'h00, 1'b1);
      send_frame();
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_summaries.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [udpfhr_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [47:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      case (idx)
         udpfhr_pkg::CSR_NEW_SOURCE_IP:  cfg_src_ip   = value[31:0];
         udpfhr_pkg::CSR_NEW_DEST_IP:    cfg_dst_ip   = value[31:0];
         udpfhr_pkg::CSR_NEW_SOURCE_MAC: cfg_src_mac  = value;
         udpfhr_pkg::CSR_NEW_DEST_MAC:   cfg_dst_mac  = value;
         udpfhr_pkg::CSR_MATCH_PORT:     cfg_match    = value[15:0];
         udpfhr_pkg::CSR_NEW_DEST_PORT:  cfg_dst_port = value[15:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input bit [31:0] sip, input bit [31:0] dip,
                                input bit [47:0] smac, input bit [47:0] dmac,
                                input bit [15:0] mport, input bit [15:0] dport);
      write_csr(udpfhr_pkg::CSR_NEW_SOURCE_IP, {16'h0000, sip});
      write_csr(udpfhr_pkg::CSR_NEW_DEST_IP, {16'h0000, dip});
      write_csr(udpfhr_pkg::CSR_NEW_SOURCE_MAC, smac);
      write_csr(udpfhr_pkg::CSR_NEW_DEST_MAC, dmac);
      write_csr(udpfhr_pkg::CSR_MATCH_PORT, {32'h0, mport});
      write_csr(udpfhr_pkg::CSR_NEW_DEST_PORT, {32'h0, dport});
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input int idle, input int stall);
      send_idle_pct = idle;
      stall_pct     = stall;
      phase_bytes   = 0;
      phase_frames  = 0;
      while (phase_bytes < 200 || phase_frames < 3) send_random_frame();
      settle();
   endtask

   initial begin : main
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < CASE_COUNT; i++) begin
         pin_case  = frame_cases[i];
         pin_typed = pin_case.typed;
         build_frame(pin_case.len, pin_case.ihl, pin_case.proto, pin_case.port,
                     pin_case.fill, pin_case.rand_fill);
         send_frame();
      end
      pin_typed = 1'b0;
      settle();
      load_settings('0, '0, '0, '0, '0, '0);
      run_phase(0, 0);
      load_settings('1, '1, '1, '1, '1, '1);
      run_phase(60, 0);
      load_settings($urandom, $urandom, {16'($urandom), 32'($urandom)},
                    {16'($urandom), 32'($urandom)}, 16'($urandom), 16'($urandom));
      run_phase(0, 60);
      load_settings($urandom, $urandom, {16'($urandom), 32'($urandom)},
                    {16'($urandom), 32'($urandom)}, 16'($urandom), 16'($urandom));
      run_phase(37, 37);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
